// ===== rtl/sorted_priority_queue_core_macros.svh =====
// Assertion macros for the sorted priority queue core.
// Files that check their own logic include this header; it depends on nothing else.
// Both macros expect signals named clk and rst_n in the including module.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define SPQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sorted priority queue check failed");
// A condition that must be followed by a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue sequencing check failed");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue core.
// Holds the transfer structs, operation codes and per-cell command struct; no dependencies.
package spq_pkg;

    // Default sizes of the queue.
    localparam int CAPACITY_DEF      = 16;
    localparam int PAYLOAD_BITS_DEF  = 32;
    localparam int PRIORITY_BITS_DEF = 16;

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } spq_op_t;

    // One request transfer.
    typedef struct packed {
        spq_op_t            operation;
        logic signed [15:0] priority_req;
        logic [31:0]        payload;
    } spq_req_t;

    // One result transfer.
    typedef struct packed {
        logic [31:0] front_payload;
        logic        front_valid;
        logic [4:0]  entry_count;
        logic        rejected;
    } spq_res_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
        logic clear;
    } spq_cmd_t;

endpackage

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue: top level with the slot chain and the entry counter.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_macros.svh.
//
// Usage:
//   A request transfer happens at a rising edge with start high and busy low.
//   busy never rises: every operation finishes in the cycle that takes it, since
//   every slot of the chain compares and shifts at once.
//   The request carries an operation (insert, remove front, clear), a priority
//   and a data word. Inserts go behind all entries of equal or higher priority.
//   In the cycle after the request transfer, done is high for exactly one cycle and
//   result holds the front data word (0 when empty), a valid flag, the entry
//   count after the operation and a reject flag for an insert into a full queue.
//   A new request may follow every cycle.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset empties the queue at once; no clearing pass is needed.
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::spq_req_t request,
    output logic              done,
    output spq_pkg::spq_res_t result
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                            take;
    logic                            full;
    logic                            empty;
    spq_cmd_t                        cmd;
    logic signed [PRIORITY_BITS-1:0] new_prio;
    logic [PAYLOAD_BITS-1:0]         new_payload;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            done_reg;
    logic                            rejected_reg;
    logic                            rejected_next;

    logic [CAPACITY-1:0]             valid_vec;
    logic [CAPACITY-1:0]             keep_vec;
    logic signed [PRIORITY_BITS-1:0] prio_arr [CAPACITY];
    logic [PAYLOAD_BITS-1:0]         payload_arr [CAPACITY];

    // Every operation completes in the cycle that takes it, so requests are never held off.
    assign busy = 1'b0;
    assign take = start && !busy;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // Fields are narrowed or widened to the stored widths.
    assign new_prio    = $signed(PRIORITY_BITS'($unsigned(request.priority_req)));
    assign new_payload = PAYLOAD_BITS'(request.payload);

    // Decode the request into the command broadcast along the chain.
    always_comb
    begin
        cmd = '0;
        if (take)
        begin
            case (request.operation)
                OP_INSERT: cmd.insert = !full;
                OP_REMOVE: cmd.remove = !empty;
                OP_CLEAR:  cmd.clear  = 1'b1;
                default:   cmd        = '0;
            endcase
        end
    end

    // Entry count and reject flag for the result.
    always_comb
    begin
        count_next    = count_reg;
        rejected_next = 1'b0;
        if (take && request.operation == OP_INSERT && full)
        begin
            rejected_next = 1'b1;
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            done_reg     <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            done_reg     <= take;
            rejected_reg <= rejected_next;
        end
    end

    // The chain of slots, front at index zero.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                            l_valid;
        logic                            l_keep;
        logic signed [PRIORITY_BITS-1:0] l_prio;
        logic [PAYLOAD_BITS-1:0]         l_payload;
        logic                            r_valid;
        logic signed [PRIORITY_BITS-1:0] r_prio;
        logic [PAYLOAD_BITS-1:0]         r_payload;

        if (i == 0)
        begin : g_head
            // On insert, the front slot takes the new entry whenever it does not keep its own.
            assign l_valid   = 1'b0;
            assign l_keep    = 1'b1;
            assign l_prio    = '0;
            assign l_payload = '0;
        end
        else
        begin : g_body
            assign l_valid   = valid_vec[i-1];
            assign l_keep    = keep_vec[i-1];
            assign l_prio    = prio_arr[i-1];
            assign l_payload = payload_arr[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign r_valid   = 1'b0;
            assign r_prio    = '0;
            assign r_payload = '0;
        end
        else
        begin : g_inner
            assign r_valid   = valid_vec[i+1];
            assign r_prio    = prio_arr[i+1];
            assign r_payload = payload_arr[i+1];
        end

        spq_cell #(
            .PAYLOAD_BITS  (PAYLOAD_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .new_prio      (new_prio),
            .new_payload   (new_payload),
            .left_valid    (l_valid),
            .left_keep     (l_keep),
            .left_prio     (l_prio),
            .left_payload  (l_payload),
            .right_valid   (r_valid),
            .right_prio    (r_prio),
            .right_payload (r_payload),
            .valid         (valid_vec[i]),
            .keep          (keep_vec[i]),
            .prio          (prio_arr[i]),
            .payload       (payload_arr[i])
        );
    end

    // Result fields are read from the state left by the last transfer.
    assign done                 = done_reg;
    assign result.front_payload = valid_vec[0] ? 32'(payload_arr[0]) : 32'd0;
    assign result.front_valid   = valid_vec[0];
    assign result.entry_count   = 5'(count_reg);
    assign result.rejected      = rejected_reg;

    // Checks on the chain and the counter.
    `SPQ_ASSERT_NEXT(a_done_follows_take, take, done)
    `SPQ_ASSERT(a_count_matches_cells, $countones(valid_vec) == int'(count_reg))
    `SPQ_ASSERT(a_front_valid_nonempty, valid_vec[0] == (count_reg != '0))
    `SPQ_ASSERT(a_reject_only_when_full, rejected_reg |-> (done_reg && full))

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: a priority, a data word and an occupied flag.
// Depends on spq_pkg for the command struct; neighbors are wired by the top level.
module spq_cell #(
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::spq_cmd_t               cmd,
    input  logic signed [PRIORITY_BITS-1:0] new_prio,
    input  logic [PAYLOAD_BITS-1:0]         new_payload,
    input  logic                            left_valid,
    input  logic                            left_keep,
    input  logic signed [PRIORITY_BITS-1:0] left_prio,
    input  logic [PAYLOAD_BITS-1:0]         left_payload,
    input  logic                            right_valid,
    input  logic signed [PRIORITY_BITS-1:0] right_prio,
    input  logic [PAYLOAD_BITS-1:0]         right_payload,
    output logic                            valid,
    output logic                            keep,
    output logic signed [PRIORITY_BITS-1:0] prio,
    output logic [PAYLOAD_BITS-1:0]         payload
);
    import spq_pkg::*;

    logic                            valid_reg;
    logic                            valid_next;
    logic signed [PRIORITY_BITS-1:0] prio_reg;
    logic signed [PRIORITY_BITS-1:0] prio_next;
    logic [PAYLOAD_BITS-1:0]         payload_reg;
    logic [PAYLOAD_BITS-1:0]         payload_next;

    // An occupied slot whose priority is at least the new one stays in place on insert.
    assign keep = valid_reg && (prio_reg >= new_prio);

    // Select the slot's next content from itself, the new entry or a neighbor.
    always_comb
    begin
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.remove)
        begin
            valid_next   = right_valid;
            prio_next    = right_prio;
            payload_next = right_payload;
        end
        else if (cmd.insert && !keep)
        begin
            if (left_keep)
            begin
                valid_next   = 1'b1;
                prio_next    = new_prio;
                payload_next = new_payload;
            end
            else
            begin
                valid_next   = left_valid;
                prio_next    = left_prio;
                payload_next = left_payload;
            end
        end
    end

    // The occupied flag is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot contents are only read while occupied.
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for sorted_priority_queue_core: directed table, then random traffic.
// Depends on spq_pkg and the core; predicts every result with its own sorted-list model.
module tb;
    import spq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;

    // One row of the directed table; exp_given marks an expectation typed in by hand.
    typedef struct {
        spq_req_t req;
        bit       exp_given;
        spq_res_t exp;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    spq_req_t  request;
    logic      done;
    spq_res_t  result;

    // Expectation attached to the request currently driven.
    bit        cur_exp_given;
    spq_res_t  cur_exp;

    // Predictor state: entries kept in descending priority order.
    logic signed [15:0] pq_prio [DEPTH];
    logic [31:0]        pq_data [DEPTH];
    int                 pq_depth;

    spq_res_t  expected_fronts [$];
    stim_row_t dir_rows [$];
    int        fail_count;
    int        items_sent;
    int        results_checked;
    int        rejects_seen;
    int        clears_seen;

    sorted_priority_queue_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = ~clk;
    end

    function automatic spq_req_t mk_req(input spq_op_t op, input logic [15:0] pr,
                                        input logic [31:0] pl);
        spq_req_t r;
        r.operation    = op;
        r.priority_req = pr;
        r.payload      = pl;
        return r;
    endfunction

    function automatic spq_res_t mk_res(input logic [31:0] pl, input logic v,
                                        input logic [4:0] cnt, input logic rj);
        spq_res_t r;
        r.front_payload = pl;
        r.front_valid   = v;
        r.entry_count   = cnt;
        r.rejected      = rj;
        return r;
    endfunction

    function automatic void add_row(input spq_req_t r, input bit given, input spq_res_t e);
        stim_row_t row;
        row.req       = r;
        row.exp_given = given;
        row.exp       = e;
        dir_rows.push_back(row);
    endfunction

    // Applies one operation to the predicted queue and returns the front it leaves.
    function automatic spq_res_t queue_apply(input spq_req_t r);
        spq_res_t           res;
        logic signed [15:0] pr;
        int                 pos;
        int                 i;
        logic               rej;
        rej = 1'b0;
        pr  = r.priority_req;
        case (r.operation)
            OP_INSERT:
            begin
                if (pq_depth >= DEPTH)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    // Equal priorities stay ahead, so a new entry lands behind them.
                    pos = 0;
                    while (pos < pq_depth && pq_prio[pos] >= pr)
                        pos++;
                    for (i = pq_depth; i > pos; i--)
                    begin
                        pq_prio[i] = pq_prio[i - 1];
                        pq_data[i] = pq_data[i - 1];
                    end
                    pq_prio[pos] = pr;
                    pq_data[pos] = r.payload;
                    pq_depth++;
                end
            end
            OP_REMOVE:
            begin
                if (pq_depth > 0)
                begin
                    for (i = 0; i + 1 < pq_depth; i++)
                    begin
                        pq_prio[i] = pq_prio[i + 1];
                        pq_data[i] = pq_data[i + 1];
                    end
                    pq_depth--;
                end
            end
            OP_CLEAR:
            begin
                pq_depth = 0;
            end
            default:
            begin
            end
        endcase
        res.front_payload = (pq_depth > 0) ? pq_data[0] : 32'd0;
        res.front_valid   = (pq_depth > 0);
        res.entry_count   = 5'(pq_depth);
        res.rejected      = rej;
        return res;
    endfunction

    // Request transfers feed the predictor; result strobes are checked against it.
    always @(posedge clk)
    begin
        spq_res_t pred;
        spq_res_t want;
        if (rst_n)
        begin
            if (start && busy === 1'b0)
            begin
                pred = queue_apply(request);
                expected_fronts.push_back(cur_exp_given ? cur_exp : pred);
                if (request.operation == OP_CLEAR)
                    clears_seen++;
            end
            if (done === 1'b1)
            begin
                if (expected_fronts.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_fronts.pop_front();
                    results_checked++;
                    if (want.rejected)
                        rejects_seen++;
                    if (result.front_payload !== want.front_payload)
                    begin
                        $error("front_payload: expected %h, got %h",
                               want.front_payload, result.front_payload);
                        fail_count++;
                    end
                    if (result.front_valid !== want.front_valid)
                    begin
                        $error("front_valid: expected %b, got %b",
                               want.front_valid, result.front_valid);
                        fail_count++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, result.entry_count);
                        fail_count++;
                    end
                    if (result.rejected !== want.rejected)
                    begin
                        $error("rejected: expected %b, got %b",
                               want.rejected, result.rejected);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Drives one request after a gap and waits for its transfer.
    task automatic send_item(input spq_req_t r, input bit given, input spq_res_t e,
                             input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start         <= 1'b1;
        request       <= r;
        cur_exp_given <= given;
        cur_exp       <= e;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        spq_res_t none_res;
        spq_req_t r;
        spq_op_t  op;
        logic [15:0] pr;
        int       k;
        int       bias;
        int       pick;
        int       ins_lim;
        int       rem_lim;
        int       clr_lim;
        bit       burst;

        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        cur_exp_given   = 1'b0;
        cur_exp         = '0;
        pq_depth        = 0;
        fail_count      = 0;
        items_sent      = 0;
        results_checked = 0;
        rejects_seen    = 0;
        clears_seen     = 0;
        none_res        = '0;
        bias            = 0;
        burst           = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty queue: remove and the unused code change nothing.
        add_row(mk_req(OP_REMOVE, 16'h0000, 32'h0), 1, mk_res(32'h0, 0, 0, 0));
        add_row(mk_req(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF), 1, mk_res(32'h0, 0, 0, 0));
        // Priority extremes, and a tie that must stay behind the first one.
        add_row(mk_req(OP_INSERT, 16'h8000, 32'hFFFF_FFFF), 1,
                mk_res(32'hFFFF_FFFF, 1, 1, 0));
        add_row(mk_req(OP_INSERT, 16'h7FFF, 32'h0), 1, mk_res(32'h0, 1, 2, 0));
        add_row(mk_req(OP_INSERT, 16'h7FFF, 32'h1234_5678), 1, mk_res(32'h0, 1, 3, 0));
        // Fill to capacity with spread priorities.
        for (k = 0; k < 13; k++)
            add_row(mk_req(OP_INSERT, 16'(k * 4500 - 27000), 32'hA500_0000 | k), 0, none_res);
        // Full queue: insert is rejected, the unused code reports the front.
        add_row(mk_req(OP_INSERT, 16'h0000, 32'h5A5A_5A5A), 1, mk_res(32'h0, 1, 16, 1));
        add_row(mk_req(OP_NONE, 16'h0000, 32'h0), 1, mk_res(32'h0, 1, 16, 0));
        add_row(mk_req(OP_REMOVE, 16'h0000, 32'h0), 1, mk_res(32'h1234_5678, 1, 15, 0));
        add_row(mk_req(OP_REMOVE, 16'h0000, 32'h0), 0, none_res);
        add_row(mk_req(OP_CLEAR, 16'h0000, 32'h0), 1, mk_res(32'h0, 0, 0, 0));
        add_row(mk_req(OP_REMOVE, 16'h0000, 32'h0), 1, mk_res(32'h0, 0, 0, 0));

        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].exp_given, dir_rows[i].exp,
                      $urandom_range(0, 5));

        // Random phases: each one leans toward filling, draining or balance.
        for (k = 0; k < 1450; k++)
        begin
            if (k % 50 == 0)
            begin
                bias  = $urandom_range(0, 2);
                burst = ($urandom_range(0, 3) == 0);
            end
            case (bias)
                0:       begin ins_lim = 75; rem_lim = 96; clr_lim = 97; end
                1:       begin ins_lim = 30; rem_lim = 94; clr_lim = 95; end
                default: begin ins_lim = 50; rem_lim = 94; clr_lim = 96; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < ins_lim)
                op = OP_INSERT;
            else if (pick < rem_lim)
                op = OP_REMOVE;
            else if (pick < clr_lim)
                op = OP_CLEAR;
            else
                op = OP_NONE;
            // Small priorities make ties common; extremes and full range fill the rest.
            case ($urandom_range(0, 3))
                0, 1:    pr = 16'($urandom);
                2:       pr = 16'($urandom_range(0, 3)) - 16'd2;
                default: pr = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            endcase
            r = mk_req(op, pr, $urandom);
            send_item(r, 0, none_res, burst ? 0 : $urandom_range(0, 5));
        end

        @(negedge clk);
        start <= 1'b0;

        while (expected_fronts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests, checked %0d results, %0d rejected inserts, %0d clears.",
                 items_sent, results_checked, rejects_seen, clears_seen);
        if (fail_count == 0)
            $display("** sorted_priority_queue_core: PASSED **");
        else
            $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results still outstanding.", expected_fronts.size());
        $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
dv/tb.sv
